// ----- design/hint_pattern_search_assert.svh -----
// ----------------------------------------------------------------------------
// hint_pattern_search_assert.svh
// Assertion macros shared by the pattern search block. Each macro expects
// clk and arst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef HINT_PATTERN_SEARCH_ASSERT_SVH
`define HINT_PATTERN_SEARCH_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define HPS_ASSERT_IMPL(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// condition must hold in the cycle after the trigger
`define HPS_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ----- design/hps_pkg.sv -----
// ----------------------------------------------------------------------------
// hps_pkg
// Types and constants of the pattern search block: built-in key prefixes,
// override limits and configuration register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hps_pkg;

	typedef logic [7:0] byte_t;

	// override pattern limit and length field width
	localparam int OVR_MAX = 16;
	localparam int LEN_W   = 5;

	// built-in key prefixes
	localparam int HINT_COUNT = 5;
	localparam int HINT_MAX   = 9;

	localparam byte_t HINT_TEXT [HINT_COUNT][HINT_MAX] = '{
		'{8'h62, 8'h6f, 8'h6f, 8'h74, 8'h63, 8'h6d, 8'h64, 8'h3d, 8'h00}, // bootcmd=
		'{8'h62, 8'h6f, 8'h6f, 8'h74, 8'h61, 8'h72, 8'h67, 8'h73, 8'h3d}, // bootargs=
		'{8'h62, 8'h61, 8'h75, 8'h64, 8'h72, 8'h61, 8'h74, 8'h65, 8'h3d}, // baudrate=
		'{8'h65, 8'h74, 8'h68, 8'h61, 8'h64, 8'h64, 8'h72, 8'h3d, 8'h00}, // ethaddr=
		'{8'h73, 8'h74, 8'h64, 8'h69, 8'h6e, 8'h3d, 8'h00, 8'h00, 8'h00}  // stdin=
	};

	localparam logic [LEN_W-1:0] HINT_LEN [HINT_COUNT] = '{
		5'd8, 5'd9, 5'd9, 5'd8, 5'd6
	};

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_OVR_LENGTH = 2'd0,
		REG_OVR_LOW    = 2'd1,
		REG_OVR_HIGH   = 2'd2
	} reg_index_t;

endpackage

// ----- design/hps_in_if.sv -----
// ----------------------------------------------------------------------------
// hps_in_if
// Input channel of the pattern search block: one buffer byte per request,
// with first and last marks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hps_in_if import hps_pkg::*; ();

	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  first_byte;
	logic  last_byte;

	modport source (output valid, output data_byte, output first_byte,
		output last_byte, input ready);
	modport sink (input valid, input data_byte, input first_byte,
		input last_byte, output ready);

endinterface

// ----- design/hps_out_if.sv -----
// ----------------------------------------------------------------------------
// hps_out_if
// Result channel of the pattern search block: one found flag per buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hps_out_if import hps_pkg::*; ();

	logic valid;
	logic ready;
	logic pattern_found;

	modport source (output valid, output pattern_found, input ready);
	modport sink (input valid, input pattern_found, output ready);

endinterface

// ----- design/hint_pattern_search.sv -----
// ----------------------------------------------------------------------------
// hint_pattern_search: a last-byte request passes the input register, then the result register
// throughput one byte per cycle unless a last byte stalls, set by the single window update per cycle
// a last byte waits in the input register only while the result register is full
// reset clears window, byte count, found flag, override registers, all valids
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "hint_pattern_search_assert.svh"

module hint_pattern_search import hps_pkg::*; #(
	parameter int WINDOW_BYTES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	hps_in_if.sink             bytes,
	hps_out_if.source          result
);

	localparam int CNT_W = $clog2(WINDOW_BYTES + 1);
	localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_BYTES);
	localparam logic [CMP_W-1:0] WIN_LEN  = CMP_W'(WINDOW_BYTES);
	localparam int PAD_W = (WINDOW_BYTES > OVR_MAX) ? WINDOW_BYTES : OVR_MAX;

	// configuration registers
	logic [LEN_W-1:0] ovr_len_q;
	logic [63:0]      ovr_low_q;
	logic [63:0]      ovr_high_q;

	// input stage
	logic  valid_s1;
	byte_t data_s1;
	logic  first_s1;
	logic  last_s1;

	// search state
	byte_t            window_q [WINDOW_BYTES];
	logic [CNT_W-1:0] cnt_q;
	logic             match_q;

	// result register
	logic out_valid_q;
	logic out_found_q;

	// next-state logic
	logic             stall;
	logic             adv_s1;
	byte_t            win_new [WINDOW_BYTES];
	byte_t            win_pad [PAD_W];
	logic [CNT_W-1:0] cnt_base;
	logic [CNT_W-1:0] cnt_new;
	logic [CMP_W-1:0] cnt_cmp;
	byte_t            ovr_pat [OVR_MAX];
	logic [LEN_W-1:0] ovr_len_eff;
	logic [OVR_MAX:0] len_hit;
	logic             ovr_hit;
	logic             hint_hit;
	logic             match_next;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovr_len_q  <= '0;
			ovr_low_q  <= '0;
			ovr_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OVR_LENGTH: ovr_len_q  <= cfg_data[LEN_W-1:0];
				REG_OVR_LOW:    ovr_low_q  <= cfg_data;
				REG_OVR_HIGH:   ovr_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a last byte holds while the previous result is still unread
	assign stall       = valid_s1 && last_s1 && out_valid_q && !result.ready;
	assign adv_s1      = valid_s1 && !stall;
	assign bytes.ready = !stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			data_s1  <= bytes.data_byte;
			first_s1 <= bytes.first_byte;
			last_s1  <= bytes.last_byte;
		end
	end

	// shifted window and byte count, cleared by a first mark
	always_comb begin
		win_new[0] = data_s1;
		for (int i = 1; i < WINDOW_BYTES; i++) begin
			win_new[i] = first_s1 ? 8'h00 : window_q[i-1];
		end
		for (int i = 0; i < PAD_W; i++) begin
			win_pad[i] = (i < WINDOW_BYTES) ? win_new[i] : 8'h00;
		end
		cnt_base = first_s1 ? '0 : cnt_q;
		cnt_new  = (cnt_base < CNT_FULL) ? cnt_base + 1'b1 : cnt_base;
		cnt_cmp  = CMP_W'(cnt_new);
	end

	// override pattern compare, one hit per possible length
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			ovr_pat[k]     = ovr_low_q[8*k +: 8];
			ovr_pat[k + 8] = ovr_high_q[8*k +: 8];
		end
		ovr_len_eff = (ovr_len_q > LEN_W'(OVR_MAX)) ? LEN_W'(OVR_MAX) : ovr_len_q;
		len_hit[0] = 1'b0;
		for (int l = 1; l <= OVR_MAX; l++) begin
			len_hit[l] = 1'b1;
			for (int k = 0; k < l; k++) begin
				if (win_pad[l-1-k] != ovr_pat[k]) begin
					len_hit[l] = 1'b0;
				end
			end
		end
		ovr_hit = len_hit[ovr_len_eff]
			&& (CMP_W'(ovr_len_eff) <= WIN_LEN)
			&& (cnt_cmp >= CMP_W'(ovr_len_eff));
	end

	// built-in key prefixes
	always_comb begin
		logic hit_one;
		hint_hit = 1'b0;
		for (int h = 0; h < HINT_COUNT; h++) begin
			hit_one = (cnt_cmp >= CMP_W'(HINT_LEN[h]));
			for (int k = 0; k < HINT_MAX; k++) begin
				if (k < int'(HINT_LEN[h])) begin
					if (win_pad[int'(HINT_LEN[h]) - 1 - k] != HINT_TEXT[h][k]) begin
						hit_one = 1'b0;
					end
				end
			end
			hint_hit = hint_hit | hit_one;
		end
	end

	// sticky found flag including this byte
	assign match_next = ((first_s1 ? 1'b0 : match_q)
		| ((ovr_len_q != '0) ? ovr_hit : hint_hit));

	// window shift register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_BYTES; i++) begin
				window_q[i] <= 8'h00;
			end
		end else if (adv_s1) begin
			for (int i = 0; i < WINDOW_BYTES; i++) begin
				window_q[i] <= win_new[i];
			end
		end
	end

	// count and flag, restarted after each buffer end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			match_q <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				cnt_q   <= '0;
				match_q <= 1'b0;
			end else begin
				cnt_q   <= cnt_new;
				match_q <= match_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_found_q <= match_next;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.pattern_found = out_found_q;

	// checks
	`HPS_ASSERT_NEXT(a_result_on_last, adv_s1 && last_s1,
		out_valid_q && (out_found_q == $past(match_next)), "result missing after last byte")
	`HPS_ASSERT_NEXT(a_restart_after_last, adv_s1 && last_s1,
		(cnt_q == '0) && !match_q, "count or flag not cleared after last byte")
	`HPS_ASSERT_IMPL(a_count_bound, 1'b1, cnt_q <= CNT_FULL, "byte count above window size")
	`HPS_ASSERT_NEXT(a_stall_holds, stall,
		valid_s1 && last_s1 && $stable(data_s1), "stalled last byte lost")

endmodule
